@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/slc_pkg.sv @@
package slc_pkg;
	localparam int MemoryBytes = 16384;
	localparam int LineWidth = 256;
	localparam int SpriteSlots = 64;
	localparam int SpritesPerLine = 8;
	localparam int AddrW = 14;
	localparam int ColW = 8;
	localparam int PixW = 7;
	localparam logic [7:0] EndMark = 8'd208;
	localparam logic [7:0] YWrap = 8'd240;
	localparam logic [6:0] SpriteMark = 7'h50;

	typedef enum logic [1:0] {
		ACT_WR_MEM = 2'd0,
		ACT_WR_PIX = 2'd1,
		ACT_RENDER = 2'd2,
		ACT_RD_PIX = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CFG_PAGE = 3'd0,
		CFG_TALL = 3'd1,
		CFG_ZOOM = 3'd2,
		CFG_SHIFT = 3'd3,
		CFG_PHIGH = 3'd4,
		CFG_LIMIT = 3'd5
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEMOP,
		ST_RDWAIT,
		ST_YREAD,
		ST_YWAIT,
		ST_XREAD,
		ST_NREAD,
		ST_NWAIT,
		ST_PREAD,
		ST_PWAIT,
		ST_PIXRD,
		ST_PIXWR,
		ST_DONE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input item
		logic mem_op;     // memory write / pixel write / pixel read issue
		logic y_rd;       // issue Y read for current slot
		logic y_eval;     // evaluate Y byte
		logic x_rd;
		logic n_rd;
		logic n_cap;      // capture pattern number
		logic p_rd;       // issue pattern byte read (count in datapath)
		logic pix_rd;     // issue line buffer read for current pixel
		logic pix_wr;     // merge and write pixel, advance
		logic next_slot;
		logic out_load;   // load result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_render;
		logic slot_last;
		logic end_mark;
		logic y_hit;
		logic limit_hit;
		logic p_last;
		logic pix_none;   // no pixel left to draw
		logic pix_last;
	} status_t;
endpackage

@@ hw/rtl/slc_ctrl.sv @@
module slc_ctrl
	import slc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd,
	output logic    busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_MEMOP;
			ST_MEMOP: state_d = st.is_render ? ST_YREAD : ST_RDWAIT;
			ST_RDWAIT: state_d = ST_DONE;
			ST_YREAD: state_d = ST_YWAIT;
			ST_YWAIT: begin
				if (st.end_mark) state_d = ST_DONE;
				else if (!st.y_hit) state_d = st.slot_last ? ST_DONE : ST_YREAD;
				else if (st.limit_hit) state_d = ST_DONE;
				else state_d = ST_XREAD;
			end
			ST_XREAD: state_d = ST_NREAD;
			ST_NREAD: state_d = ST_NWAIT;
			ST_NWAIT: state_d = ST_PREAD;
			ST_PREAD: if (st.p_last) state_d = ST_PWAIT;
			ST_PWAIT: state_d = st.pix_none ? (st.slot_last ? ST_DONE : ST_YREAD) : ST_PIXRD;
			ST_PIXRD: state_d = ST_PIXWR;
			ST_PIXWR: begin
				if (!st.pix_last) state_d = ST_PIXRD;
				else state_d = st.slot_last ? ST_DONE : ST_YREAD;
			end
			ST_DONE: state_d = ST_OUT;
			ST_OUT: if (!out_valid || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load = in_fire;
			ST_MEMOP: cmd.mem_op = 1'b1;
			ST_YREAD: cmd.y_rd = 1'b1;
			ST_YWAIT: begin
				cmd.y_eval = 1'b1;
				cmd.next_slot = !st.end_mark && !st.y_hit;
			end
			ST_XREAD: cmd.x_rd = 1'b1;
			ST_NREAD: cmd.n_rd = 1'b1;
			ST_NWAIT: cmd.n_cap = 1'b1;
			ST_PREAD: cmd.p_rd = 1'b1;
			ST_PWAIT: cmd.next_slot = st.pix_none;
			ST_PIXRD: cmd.pix_rd = 1'b1;
			ST_PIXWR: begin
				cmd.pix_wr = 1'b1;
				cmd.next_slot = st.pix_last;
			end
			ST_OUT: cmd.out_load = !out_valid || !out_stall;
			default: cmd = '0;
		endcase
	end

	assign busy = state_q != ST_IDLE;
endmodule

@@ hw/rtl/slc_datapath.sv @@
`include "assert_macros.svh"
module slc_datapath
	import slc_pkg::*;
#(
	parameter int SPRITE_SLOTS = SpriteSlots,
	parameter int SPRITES_PER_LINE = SpritesPerLine
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     st,
	input  logic [1:0]  action,
	input  logic [13:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  scan_line,
	input  logic [5:0]  page,
	input  logic        tall,
	input  logic        zoom,
	input  logic        shl,
	input  logic        phigh,
	input  logic        limit_on,
	output logic [6:0]  pixel,
	output logic        collision,
	output logic        out_valid,
	input  logic        out_stall
);
	localparam int SlotW = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
	localparam int CntW = $clog2(SPRITES_PER_LINE + 2);

	logic [7:0] vmem [MemoryBytes];
	logic [6:0] lbuf [LineWidth];

	logic [1:0] act_q;
	logic [13:0] addr_q;
	logic [7:0] data_q, line_q;
	logic [7:0] rd_q;
	logic [6:0] lb_q;
	logic [SlotW-1:0] slot_q;
	logic [CntW-1:0] cnt_q;
	logic [4:0] row_q;
	logic [8:0] n_q;
	logic signed [9:0] xp_q;
	logic [1:0] pcnt_q;
	logic [7:0] p0_q, p1_q, p2_q, p3_q;
	logic [4:0] x_q, x_end_q;
	logic hit_q;

	logic mem_we;
	logic [13:0] mem_ra;
	logic [13:0] base;
	logic [13:0] paddr;
	logic [8:0] yw;
	logic signed [9:0] diff;
	logic [4:0] height, width;
	logic [2:0] sh;
	logic [3:0] s;
	logic [7:0] col;
	logic signed [10:0] xstart, xend;
	logic [4:0] st_x, en_x;
	logic [7:0] x_byte;

	assign base = {page, 8'h00};
	assign height = zoom ? (tall ? 5'd0 : 5'd16) : (tall ? 5'd16 : 5'd8);
	assign width = zoom ? 5'd16 : 5'd8;

	// Y evaluation on the freshly read byte
	assign yw = (rd_q + 8'd1 > {1'b0, YWrap}) ? {1'b0, rd_q} + 9'd1 - 9'd256
		: {1'b0, rd_q} + 9'd1;
	assign diff = $signed({2'b00, line_q}) - $signed({yw[8], yw});
	assign st.end_mark = rd_q == EndMark;
	assign st.y_hit = !diff[9] && ((zoom && tall) ? (diff < 10'sd32)
		: (diff < $signed({5'd0, height})));
	assign st.limit_hit = limit_on && (cnt_q == CntW'(SPRITES_PER_LINE));
	assign st.slot_last = slot_q == SlotW'(SPRITE_SLOTS - 1);
	assign st.is_render = act_q == ACT_RENDER;
	assign st.p_last = pcnt_q == 2'd3;

	assign paddr = 14'({n_q, 5'd0} + {7'd0, row_q[3:0], 2'd0} + {12'd0, pcnt_q});

	assign x_byte = rd_q;
	always_comb begin
		xstart = shl ? ($signed({3'd0, x_byte}) - 11'sd8) : $signed({3'd0, x_byte});
		xend = xstart + $signed({6'd0, width});
		st_x = (xstart < 0) ? 5'(-xstart) : 5'd0;
		en_x = (xend > 11'sd256) ? 5'(11'sd256 - xstart) : width;
	end
	assign st.pix_none = x_q >= x_end_q;
	assign st.pix_last = x_q + 5'd1 >= x_end_q;

	assign sh = 3'd7 - (zoom ? x_q[3:1] : x_q[2:0]);
	assign s = {p3_q[sh], p2_q[sh], p1_q[sh], p0_q[sh]};
	assign col = 8'(xp_q + $signed({5'd0, x_q}));

	always_comb begin
		mem_ra = addr_q;
		if (cmd.y_rd) mem_ra = base + 14'(slot_q);
		else if (cmd.x_rd) mem_ra = base + 14'h80 + 14'({slot_q, 1'b0});
		else if (cmd.n_rd) mem_ra = base + 14'h81 + 14'({slot_q, 1'b0});
		else if (cmd.p_rd) mem_ra = paddr;
	end
	assign mem_we = cmd.mem_op && act_q == ACT_WR_MEM;

	always_ff @(posedge clk) begin
		if (mem_we) vmem[addr_q] <= data_q;
		rd_q <= vmem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_op && act_q == ACT_WR_PIX) lbuf[addr_q[7:0]] <= data_q[6:0];
		else if (cmd.pix_wr && s != 4'd0 && !lb_q[6] && !(lb_q[5] && lb_q[3:0] != 4'd0))
			lbuf[col] <= {3'b101, s};
		lb_q <= lbuf[cmd.pix_rd ? col : addr_q[7:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			addr_q <= address;
			data_q <= data;
			line_q <= scan_line;
		end
		if (cmd.y_eval) begin
			row_q <= zoom ? 5'(diff >>> 1) : 5'(diff);
		end
		if (cmd.n_rd) xp_q <= xstart[9:0];
		if (cmd.n_rd) begin
			x_q <= st_x;
			x_end_q <= en_x;
		end
		if (cmd.pix_wr) x_q <= x_q + 5'd1;
	end

	// pattern fetch: read issued in PREAD, data lands in the next cycle
	logic p_rd_d;
	logic [1:0] pcnt_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			p_rd_d <= 1'b0;
			pcnt_d <= '0;
			slot_q <= '0;
			cnt_q <= '0;
			hit_q <= 1'b0;
			out_valid <= 1'b0;
			n_q <= '0;
		end else begin
			p_rd_d <= cmd.p_rd;
			pcnt_d <= pcnt_q;
			if (cmd.p_rd) pcnt_q <= pcnt_q + 2'd1;
			if (cmd.n_cap) begin
				n_q <= ({phigh, rd_q}) & {8'hFF, !tall};
			end
			if (cmd.load) begin
				slot_q <= '0;
				cnt_q <= '0;
				hit_q <= 1'b0;
			end
			if (cmd.y_eval && st.y_hit && !st.end_mark && !st.limit_hit)
				cnt_q <= cnt_q + CntW'(1);
			if (cmd.next_slot) slot_q <= slot_q + SlotW'(1);
			if (cmd.pix_wr && s != 4'd0 && lb_q[6]) hit_q <= 1'b1;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (p_rd_d) case (pcnt_d)
			2'd0: p0_q <= rd_q;
			2'd1: p1_q <= rd_q;
			2'd2: p2_q <= rd_q;
			default: p3_q <= rd_q;
		endcase
		if (cmd.out_load) begin
			case (act_q)
				ACT_WR_PIX: pixel <= data_q[6:0];
				ACT_RD_PIX: pixel <= lb_q;
				default: pixel <= '0;
			endcase
			collision <= (act_q == ACT_RENDER) && hit_q;
		end
	end

	`ASSERT_IMPL(a_pcnt_wrap, clk, arst_n, cmd.load, pcnt_q == 2'd0,
		"pattern counter not idle at item start")
	`ASSERT_IMPL(a_one_rd, clk, arst_n, cmd.y_rd, !cmd.p_rd && !cmd.x_rd,
		"two video memory reads in one cycle")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"result dropped while stalled")
endmodule

@@ hw/rtl/sprite_line_compositor_top.sv @@
// Sequence: memory and pixel items pass MEMOP, RDWAIT, DONE and OUT after acceptance.
// A render reads the Y byte of each table slot scanned (YREAD, YWAIT); for each sprite on
// the line it reads X, the pattern number and four pattern bytes, then reads and writes
// each drawn pixel (PIXRD, PIXWR); it ends with DONE and OUT.
// Throughput: one item at a time, taken once the result loads.
// Reset initializes control and config registers; memories are undefined until written.
`include "assert_macros.svh"
module sprite_line_compositor_top
	import slc_pkg::*;
#(
	parameter int SPRITE_SLOTS = SpriteSlots,
	parameter int SPRITES_PER_LINE = SpritesPerLine
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [13:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  scan_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  pixel,
	output logic        collision,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	cmd_t cmd;
	status_t st;
	logic busy, in_fire;
	logic [5:0] page_q;
	logic tall_q, zoom_q, shl_q, phigh_q, limit_q;

	// take one item only while idle
	assign in_stall = busy;
	assign in_fire = in_valid && !busy;
	assign cfg_ready = 1'b1;

	// config registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= 6'd63;
			tall_q <= 1'b0;
			zoom_q <= 1'b0;
			shl_q <= 1'b0;
			phigh_q <= 1'b0;
			limit_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PAGE: page_q <= cfg_data[5:0];
				CFG_TALL: tall_q <= cfg_data[0];
				CFG_ZOOM: zoom_q <= cfg_data[0];
				CFG_SHIFT: shl_q <= cfg_data[0];
				CFG_PHIGH: phigh_q <= cfg_data[0];
				CFG_LIMIT: limit_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	slc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_valid(out_valid),
		.out_stall(out_stall), .st(st), .cmd(cmd), .busy(busy)
	);

	slc_datapath #(
		.SPRITE_SLOTS(SPRITE_SLOTS), .SPRITES_PER_LINE(SPRITES_PER_LINE)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.action(action), .address(address), .data(data), .scan_line(scan_line),
		.page(page_q), .tall(tall_q), .zoom(zoom_q), .shl(shl_q),
		.phigh(phigh_q), .limit_on(limit_q),
		.pixel(pixel), .collision(collision), .out_valid(out_valid),
		.out_stall(out_stall)
	);

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, busy, in_stall,
		"item accepted while busy")
	`ASSERT_NEXT(a_fire_busy, clk, arst_n, in_fire, busy,
		"controller did not start on accepted item")
endmodule
